// ----- hdl/hcbp_pkg.sv -----
// shared types and constants for the huffman code bit packer
package hcbp_pkg;

  localparam int SYM_W   = 7;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               is_final;
    logic [TOTAL_W-1:0] total_bits;
    logic               last;
  } res_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_SECOND
  } back_state_t;

endpackage

// ----- hdl/hcbp_queue.sv -----
// two-entry queue used between the front, the back and the result port
module hcbp_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  T           slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/hcbp_front.sv -----
// front end: code table, load handling and command issue
module hcbp_front
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT    = 128,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CODE_W-1:0] code_bits,
  input  logic [LEN_W-1:0]  code_length,
  output logic              cmd_push,
  output cmd_t              cmd_data,
  input  logic              cmd_full
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LIMIT = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;

  logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;

  logic                    accept;
  logic [8:0]              sym_wide;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_W:0]         mask_wide;
  logic [CODE_W-1:0]       code_masked;

  logic                    s1_valid;
  logic                    s1_valid_next;
  logic                    s1_flush;
  logic                    s1_hit;
  logic [CODE_W+LEN_W-1:0] s1_entry;

  assign accept   = push && !full;
  assign full     = s1_valid && cmd_full;
  assign sym_wide = {2'b00, symbol};
  assign in_range = sym_wide < 9'(SYMBOL_COUNT);
  assign idx      = sym_wide[IDX_W-1:0];

  // saturate the length and drop code bits above it
  assign len_sat     = (code_length > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : code_length;
  assign mask_wide   = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
  assign code_masked = code_bits & mask_wide[CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && action == ACT_LOAD && in_range) begin
      mem[idx] <= {code_masked, len_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_entry <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (accept && action == ACT_LOAD && in_range) begin
      vld[idx] <= 1'b1;
    end
  end

  always_comb begin
    s1_valid_next = s1_valid && cmd_full;
    if (accept && (action == ACT_ENCODE || action == ACT_FLUSH)) begin
      s1_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= (action == ACT_FLUSH);
      s1_hit   <= (action == ACT_ENCODE) && in_range && vld[idx];
    end
  end

  // a symbol never loaded issues a zero-length encode
  assign cmd_push          = s1_valid && !cmd_full;
  assign cmd_data.is_flush = s1_flush;
  assign cmd_data.code     = s1_entry[CODE_W+LEN_W-1:LEN_W];
  assign cmd_data.len      = s1_hit ? s1_entry[LEN_W-1:0] : '0;

endmodule

// ----- hdl/hcbp_back.sv -----
// back end: bit packing, byte emission and flush
module hcbp_back
  import hcbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd_data,
  output logic cmd_pop,
  output logic res_push,
  output res_t res_data,
  input  logic res_full
);

  back_state_t        state;
  back_state_t        state_next;
  logic [BYTE_W-1:0]  acc;
  logic [BYTE_W-1:0]  acc_next;
  logic [2:0]         nbits;
  logic [2:0]         nbits_next;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [BYTE_W-1:0]  pend;
  logic [BYTE_W-1:0]  pend_next;

  logic [CODE_W-1:0]  code_left;
  logic [23:0]        window;
  logic [LEN_W-1:0]   bit_sum;
  logic [1:0]         nbytes;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_sat;

  assign code_left = cmd_data.code << (LEN_W'(CODE_W) - cmd_data.len);
  assign window    = {acc, 16'h0000} | ({code_left, 8'h00} >> nbits);
  assign bit_sum   = {2'b00, nbits} + cmd_data.len;
  assign nbytes    = bit_sum[4:3];
  assign total_sum = {1'b0, total} + (TOTAL_W+1)'(cmd_data.len);
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  always_comb begin
    state_next = state;
    acc_next   = acc;
    nbits_next = nbits;
    total_next = total;
    pend_next  = pend;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    case (state)
      BACK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd_data.is_flush) begin
            res_push            = 1'b1;
            res_data.out_byte   = (nbits != 3'd0) ? acc : '0;
            res_data.byte_valid = (nbits != 3'd0);
            res_data.is_final   = 1'b1;
            res_data.total_bits = total;
            res_data.last       = 1'b1;
            acc_next            = '0;
            nbits_next          = '0;
            total_next          = '0;
          end else begin
            nbits_next = bit_sum[2:0];
            total_next = total_sat;
            case (nbytes)
              2'd0:    acc_next = window[23:16];
              2'd1:    acc_next = window[15:8];
              default: acc_next = window[7:0];
            endcase
            if (nbytes != 2'd0) begin
              res_push            = 1'b1;
              res_data.out_byte   = window[23:16];
              res_data.byte_valid = 1'b1;
              res_data.last       = (nbytes == 2'd1);
            end
            if (nbytes == 2'd2) begin
              pend_next  = window[15:8];
              state_next = BACK_SECOND;
            end
          end
        end
      end
      BACK_SECOND: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_data.out_byte   = pend;
          res_data.byte_valid = 1'b1;
          res_data.last       = 1'b1;
          state_next          = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BACK_IDLE;
      acc   <= '0;
      nbits <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      nbits <= nbits_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

endmodule

// ----- hdl/huffman_code_bit_packer_unit.sv -----
// Huffman code bit packer: a request passes the front stage register, the command queue
// and the result queue on its way to the outputs. An encode that completes two bytes writes
// them in turn through the packing stage's single result write port, taking no new command meanwhile.
// Synchronous active-high reset clears the code table valid bits, the packer and
// all queues; the table is usable in the cycle after reset is released.
module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT    = 128,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [CODE_W-1:0]  code_bits,
  input  logic [LEN_W-1:0]   code_length,
  output logic               empty,
  input  logic               pop,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               byte_valid,
  output logic               is_final,
  output logic [TOTAL_W-1:0] total_bits,
  output logic               last
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;
  logic res_push;
  res_t res_in;
  logic res_full;
  res_t res_out;

  hcbp_front #(
    .SYMBOL_COUNT   (SYMBOL_COUNT),
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .symbol     (symbol),
    .code_bits  (code_bits),
    .code_length(code_length),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in),
    .cmd_full   (cmd_full)
  );

  hcbp_queue #(.T(cmd_t)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_out),
    .empty(cmd_empty)
  );

  hcbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_data (res_in),
    .res_full (res_full)
  );

  hcbp_queue #(.T(res_t)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_out),
    .empty(empty)
  );

  assign out_byte   = res_out.out_byte;
  assign byte_valid = res_out.byte_valid;
  assign is_final   = res_out.is_final;
  assign total_bits = res_out.total_bits;
  assign last       = res_out.last;

endmodule

// ----- hdl/hcbp_checker.sv -----
// port-level checks for the huffman code bit packer, bound to the top level
module hcbp_checker
  import hcbp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [BYTE_W-1:0]  out_byte,
  input logic               byte_valid,
  input logic               is_final,
  input logic [TOTAL_W-1:0] total_bits,
  input logic               last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_final) |-> last)
    else $error("flush result without last");

  a_byte_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_final) |-> (byte_valid && total_bits == '0))
    else $error("byte result with bad flags or count");

  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (is_final && out_byte == '0))
    else $error("result without data is not an empty flush");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .byte_valid(byte_valid),
  .is_final  (is_final),
  .total_bits(total_bits),
  .last      (last)
);
